// ===== hw/rtl/maskirq_pkg.sv =====
`timescale 1ns / 1ps

package maskirq_pkg;

    // line count and derived word geometry
    localparam int NUM_LINES  = 256;
    localparam int NUM_WORDS  = (NUM_LINES + 63) / 64;
    localparam int WORD_IDX_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int SEL_W      = WORD_IDX_W + 6;

    // payload widths fixed by the interface
    localparam int OPCODE_W = 3;
    localparam int LINE_W   = 8;
    localparam int WORD_W   = 2;
    localparam int MASK_W   = 64;

    // operation codes
    localparam logic [OPCODE_W-1:0] OP_MASK   = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_UNMASK = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_EOI    = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_GET    = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_LEVEL  = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC,
        ST_DELIVER
    } state_t;

    // leading zero count of a word, msb first; 0 for an empty word
    function automatic logic [5:0] lead_zeros(input logic [MASK_W-1:0] w);
        logic [5:0] n;
        logic       hit;
        n   = '0;
        hit = 1'b0;
        for (int i = 0; i < MASK_W; i++)
        begin
            if (!hit && w[MASK_W-1-i])
            begin
                n   = 6'(i);
                hit = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

// ===== hw/rtl/maskirq_if.sv =====
`timescale 1ns / 1ps

// request channel: one operation per transfer
interface maskirq_in_if;
    logic                                valid;
    logic                                ready;
    logic [maskirq_pkg::OPCODE_W-1:0]    opcode;
    logic [maskirq_pkg::LINE_W-1:0]      line_number;
    logic                                pending_level;

    modport source (output valid, opcode, line_number, pending_level, input ready);
    modport sink   (input valid, opcode, line_number, pending_level, output ready);
endinterface

// response channel: one result per transfer
interface maskirq_out_if;
    logic                                valid;
    logic                                ready;
    logic                                found;
    logic [maskirq_pkg::LINE_W-1:0]      selected_line;
    logic [maskirq_pkg::WORD_W-1:0]      word_index;
    logic [maskirq_pkg::MASK_W-1:0]      effective_mask_word;

    modport source (output valid, found, selected_line, word_index, effective_mask_word,
                    input ready);
    modport sink   (input valid, found, selected_line, word_index, effective_mask_word,
                    output ready);
endinterface

// ===== hw/rtl/masked_interrupt_priority_select.sv =====
`timescale 1ns / 1ps

// Interrupt controller with per-line enable, armed and pending bits; line n sits
// in bit 63-(n%64) of word n/64. One request is handled at a time: mask, unmask,
// end of interrupt and level update go through an execute state and a deliver
// state before the next ready; get uses a scan state in place of execute, as a
// single 64-bit compare and priority-encode unit walks the words one per cycle
// until it finds the lowest pending, enabled and armed line. Every response
// carries enable AND armed of the word touched; a get that finds nothing reports
// all zeros. The result sits in an output register, so a stalled response does
// not lose data, but the next request is taken only after it was loaded there.
module masked_interrupt_priority_select (
    input  logic                 clk,
    input  logic                 rst_n,
    maskirq_in_if.sink           req,
    maskirq_out_if.source        rsp
);

    localparam int NW = maskirq_pkg::NUM_WORDS;
    localparam int IW = maskirq_pkg::WORD_IDX_W;
    localparam int MW = maskirq_pkg::MASK_W;

    // per-line state words
    logic [MW-1:0] enable_reg  [NW];
    logic [MW-1:0] armed_reg   [NW];
    logic [MW-1:0] pending_reg [NW];

    maskirq_pkg::state_t state_reg, state_next;
    logic [IW-1:0]       word_cnt_reg, word_cnt_next;

    // captured request
    logic [maskirq_pkg::OPCODE_W-1:0] op_reg;
    logic [maskirq_pkg::LINE_W-1:0]   line_reg;
    logic                             level_reg;

    // staged result
    logic                           res_found_reg, res_found_next;
    logic [maskirq_pkg::LINE_W-1:0] res_line_reg, res_line_next;
    logic [maskirq_pkg::WORD_W-1:0] res_word_reg, res_word_next;
    logic [MW-1:0]                  res_eff_reg, res_eff_next;

    // output register
    logic                           out_valid_reg;
    logic                           out_found_reg;
    logic [maskirq_pkg::LINE_W-1:0] out_line_reg;
    logic [maskirq_pkg::WORD_W-1:0] out_word_reg;
    logic [MW-1:0]                  out_eff_reg;

    // datapath signals
    logic [IW-1:0]   line_widx;
    logic [IW-1:0]   rd_idx;
    logic [MW-1:0]   en_w, arm_w, pend_w;
    logic [MW-1:0]   cand;
    logic [5:0]      lz;
    logic [IW+5:0]   sel_full;
    logic [MW-1:0]   sel_bit;
    logic [MW-1:0]   line_bit;
    logic            in_range;
    logic            cand_hit;
    logic            scan_last;
    logic            req_xfer;
    logic            load_out;
    logic            en_we, arm_we, pend_we;
    logic [MW-1:0]   en_wdata, arm_wdata, pend_wdata;

    assign req_xfer = req.valid && req.ready;

    // shared word read: scan counter during get, addressed word otherwise
    assign line_widx = IW'(line_reg[7:6]);
    assign rd_idx    = (state_reg == maskirq_pkg::ST_SCAN) ? word_cnt_reg : line_widx;
    assign en_w      = enable_reg[rd_idx];
    assign arm_w     = armed_reg[rd_idx];
    assign pend_w    = pending_reg[rd_idx];

    // compare and priority encode unit
    assign cand      = pend_w & en_w & arm_w;
    assign cand_hit  = (cand != '0);
    assign lz        = maskirq_pkg::lead_zeros(cand);
    assign sel_full  = {word_cnt_reg, lz};
    assign sel_bit   = {{(MW-1){1'b0}}, 1'b1} << (~lz);
    assign scan_last = (int'(word_cnt_reg) == NW - 1);

    // addressed line
    assign line_bit  = {{(MW-1){1'b0}}, 1'b1} << (~line_reg[5:0]);
    assign in_range  = (int'(line_reg) < maskirq_pkg::NUM_LINES) &&
                       (int'(line_reg[7:6]) < NW);

    // next state
    always_comb
    begin
        state_next    = state_reg;
        word_cnt_next = word_cnt_reg;
        case (state_reg)
            maskirq_pkg::ST_IDLE:
            begin
                word_cnt_next = '0;
                if (req.valid)
                begin
                    if (req.opcode == maskirq_pkg::OP_GET)
                        state_next = maskirq_pkg::ST_SCAN;
                    else
                        state_next = maskirq_pkg::ST_EXEC;
                end
            end
            maskirq_pkg::ST_SCAN:
            begin
                if (cand_hit || scan_last)
                    state_next = maskirq_pkg::ST_DELIVER;
                else
                    word_cnt_next = word_cnt_reg + 1'b1;
            end
            maskirq_pkg::ST_EXEC:
            begin
                state_next = maskirq_pkg::ST_DELIVER;
            end
            maskirq_pkg::ST_DELIVER:
            begin
                if (!out_valid_reg || rsp.ready)
                    state_next = maskirq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = maskirq_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath control and result staging
    always_comb
    begin
        req.ready      = 1'b0;
        load_out       = 1'b0;
        en_we          = 1'b0;
        arm_we         = 1'b0;
        pend_we        = 1'b0;
        en_wdata       = en_w;
        arm_wdata      = arm_w;
        pend_wdata     = pend_w;
        res_found_next = res_found_reg;
        res_line_next  = res_line_reg;
        res_word_next  = res_word_reg;
        res_eff_next   = res_eff_reg;
        case (state_reg)
            maskirq_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            maskirq_pkg::ST_SCAN:
            begin
                if (cand_hit)
                begin
                    arm_we         = 1'b1;
                    arm_wdata      = arm_w & ~sel_bit;
                    res_found_next = 1'b1;
                    res_line_next  = maskirq_pkg::LINE_W'(sel_full);
                    res_word_next  = maskirq_pkg::WORD_W'(word_cnt_reg);
                    res_eff_next   = en_w & arm_w & ~sel_bit;
                end
                else if (scan_last)
                begin
                    res_found_next = 1'b0;
                    res_line_next  = '0;
                    res_word_next  = '0;
                    res_eff_next   = '0;
                end
            end
            maskirq_pkg::ST_EXEC:
            begin
                if (in_range)
                begin
                    case (op_reg)
                        maskirq_pkg::OP_MASK:
                        begin
                            en_we    = 1'b1;
                            en_wdata = en_w & ~line_bit;
                        end
                        maskirq_pkg::OP_UNMASK:
                        begin
                            en_we    = 1'b1;
                            en_wdata = en_w | line_bit;
                        end
                        maskirq_pkg::OP_EOI:
                        begin
                            arm_we    = 1'b1;
                            arm_wdata = arm_w | line_bit;
                        end
                        maskirq_pkg::OP_LEVEL:
                        begin
                            pend_we    = 1'b1;
                            pend_wdata = level_reg ? (pend_w | line_bit) : (pend_w & ~line_bit);
                        end
                        default:
                        begin
                            en_we = 1'b0;
                        end
                    endcase
                end
                res_found_next = 1'b0;
                res_line_next  = '0;
                res_word_next  = line_reg[7:6];
                res_eff_next   = in_range ? (en_wdata & arm_wdata) : '0;
            end
            maskirq_pkg::ST_DELIVER:
            begin
                load_out = !out_valid_reg || rsp.ready;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= maskirq_pkg::ST_IDLE;
            word_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            word_cnt_reg <= word_cnt_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // state words, one word written per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NW; i++)
            begin
                enable_reg[i]  <= '0;
                armed_reg[i]   <= '1;
                pending_reg[i] <= '0;
            end
        end
        else
        begin
            if (en_we)
                enable_reg[rd_idx] <= en_wdata;
            if (arm_we)
                armed_reg[rd_idx] <= arm_wdata;
            if (pend_we)
                pending_reg[rd_idx] <= pend_wdata;
        end
    end

    // request capture, staged result and output payload
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            op_reg    <= req.opcode;
            line_reg  <= req.line_number;
            level_reg <= req.pending_level;
        end
        res_found_reg <= res_found_next;
        res_line_reg  <= res_line_next;
        res_word_reg  <= res_word_next;
        res_eff_reg   <= res_eff_next;
        if (load_out)
        begin
            out_found_reg <= res_found_reg;
            out_line_reg  <= res_line_reg;
            out_word_reg  <= res_word_reg;
            out_eff_reg   <= res_eff_reg;
        end
    end

    assign rsp.valid               = out_valid_reg;
    assign rsp.found               = out_found_reg;
    assign rsp.selected_line       = out_line_reg;
    assign rsp.word_index          = out_word_reg;
    assign rsp.effective_mask_word = out_eff_reg;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

    import maskirq_pkg::*;

    // spare opcodes that the block must execute without state change
    localparam logic [OPCODE_W-1:0] OP_SPARE_A = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_SPARE_B = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE_C = 3'd7;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_TAIL  = 8;

    typedef struct packed {
        logic                found;
        logic [LINE_W-1:0]   selected_line;
        logic [WORD_W-1:0]   word_index;
        logic [MASK_W-1:0]   effective_mask_word;
    } irq_result_t;

    logic clk;
    logic rst_n;

    maskirq_in_if  req_if ();
    maskirq_out_if rsp_if ();

    masked_interrupt_priority_select i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // shadow copy of the controller state
    logic [MASK_W-1:0] enable_shadow  [NUM_WORDS];
    logic [MASK_W-1:0] armed_shadow   [NUM_WORDS];
    logic [MASK_W-1:0] pending_shadow [NUM_WORDS];

    irq_result_t expected_results[$];
    irq_result_t last_result;
    int          error_count;
    int          cycle_count;
    int          ops_sent;
    bit          no_idle;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // cycle limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: FAIL");
        $finish;
    end

    task automatic report(input string msg);
        error_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle)
            return 0;
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // expected result of one operation; updates the shadow state
    function automatic irq_result_t predict_irq(input logic [OPCODE_W-1:0] op,
                                                input logic [LINE_W-1:0] line,
                                                input logic level);
        irq_result_t       r;
        int unsigned       w;
        int unsigned       lz;
        logic [MASK_W-1:0] cand;
        logic [MASK_W-1:0] line_mask;
        bit                hit;
        r   = '0;
        hit = 1'b0;
        if (op == OP_GET)
        begin
            // lowest pending, enabled and armed line, msb of a word first
            for (int i = 0; i < NUM_WORDS; i++)
            begin
                cand = pending_shadow[i] & enable_shadow[i] & armed_shadow[i];
                if (!hit && cand != '0)
                begin
                    lz = 0;
                    while (!cand[MASK_W-1])
                    begin
                        cand = cand << 1;
                        lz++;
                    end
                    armed_shadow[i][63 - lz] = 1'b0;
                    r.found               = 1'b1;
                    r.selected_line       = LINE_W'(i * 64 + lz);
                    r.word_index          = WORD_W'(i);
                    r.effective_mask_word = enable_shadow[i] & armed_shadow[i];
                    hit = 1'b1;
                end
            end
            return r;
        end
        w = line / 64;
        r.word_index = WORD_W'(w);
        if (line >= NUM_LINES || w >= NUM_WORDS)
            return r;
        line_mask = 64'd1 << (63 - (line % 64));
        case (op)
            OP_MASK:   enable_shadow[w] &= ~line_mask;
            OP_UNMASK: enable_shadow[w] |= line_mask;
            OP_EOI:    armed_shadow[w]  |= line_mask;
            OP_LEVEL:
            begin
                if (level)
                    pending_shadow[w] |= line_mask;
                else
                    pending_shadow[w] &= ~line_mask;
            end
            default: ;
        endcase
        r.effective_mask_word = enable_shadow[w] & armed_shadow[w];
        return r;
    endfunction

    // one request transfer, then record what it should produce
    task automatic send_op(input logic [OPCODE_W-1:0] op, input logic [LINE_W-1:0] line,
                           input logic level);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            req_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_if.valid         <= 1'b1;
        req_if.opcode        <= op;
        req_if.line_number   <= line;
        req_if.pending_level <= level;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        last_result = predict_irq(op, line, level);
        expected_results.push_back(last_result);
        ops_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (expected_results.size() > 0)
            @(posedge clk);
    endtask

    // response side: random stalls
    initial
    begin
        int stall_left;
        stall_left = 0;
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                stall_left = pick_gap();
                rsp_if.ready <= (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        irq_result_t exp_r;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (expected_results.size() == 0)
                report($sformatf("unexpected result line=%0d word=%0d",
                                 rsp_if.selected_line, rsp_if.word_index));
            else
            begin
                exp_r = expected_results.pop_front();
                if (rsp_if.found !== exp_r.found)
                    report($sformatf("found %0b, expected %0b", rsp_if.found, exp_r.found));
                if (rsp_if.selected_line !== exp_r.selected_line)
                    report($sformatf("selected_line %0d, expected %0d",
                                     rsp_if.selected_line, exp_r.selected_line));
                if (rsp_if.word_index !== exp_r.word_index)
                    report($sformatf("word_index %0d, expected %0d",
                                     rsp_if.word_index, exp_r.word_index));
                if (rsp_if.effective_mask_word !== exp_r.effective_mask_word)
                    report($sformatf("effective_mask_word %h, expected %h",
                                     rsp_if.effective_mask_word, exp_r.effective_mask_word));
            end
        end
    end

    // empty controller, first grant, disarm and re-arm
    task automatic test_first_grant();
        send_op(OP_GET, 8'd0, 1'b0);
        send_op(OP_UNMASK, 8'd0, 1'b0);
        send_op(OP_LEVEL, 8'd0, 1'b1);
        send_op(OP_GET, 8'd0, 1'b0);
        send_op(OP_GET, 8'd0, 1'b0);
        send_op(OP_EOI, 8'd0, 1'b0);
        send_op(OP_GET, 8'd0, 1'b0);
    endtask

    // top line and word boundaries
    task automatic test_line_extremes();
        send_op(OP_UNMASK, 8'd255, 1'b0);
        send_op(OP_LEVEL, 8'd255, 1'b1);
        send_op(OP_GET, 8'd0, 1'b0);
        send_op(OP_MASK, 8'd255, 1'b0);
        send_op(OP_EOI, 8'd255, 1'b0);
        send_op(OP_LEVEL, 8'd255, 1'b0);
        send_op(OP_UNMASK, 8'd64, 1'b0);
        send_op(OP_UNMASK, 8'd63, 1'b0);
        send_op(OP_LEVEL, 8'd63, 1'b1);
        send_op(OP_LEVEL, 8'd64, 1'b1);
        send_op(OP_GET, 8'd0, 1'b0);
        send_op(OP_GET, 8'd0, 1'b0);
    endtask

    // unused opcodes leave the state alone
    task automatic test_spare_opcodes();
        send_op(OP_SPARE_A, 8'd200, 1'b1);
        send_op(OP_SPARE_B, 8'd127, 1'b0);
        send_op(OP_SPARE_C, 8'd0, 1'b1);
        send_op(OP_GET, 8'd0, 1'b0);
    endtask

    // unmask, raise, take, acknowledge, with random lines
    task automatic test_service_flows(input int n_ops);
        int               stop_at;
        logic [LINE_W-1:0] line;
        stop_at = ops_sent + n_ops;
        while (ops_sent < stop_at)
        begin
            if ($urandom_range(0, 7) == 0)
                no_idle = ~no_idle;
            line = LINE_W'($urandom_range(0, 255));
            send_op(OP_UNMASK, line, 1'($urandom_range(0, 1)));
            send_op(OP_LEVEL, line, 1'b1);
            send_op(OP_GET, LINE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 3) == 0)
                send_op(OP_GET, line, 1'b0);
            if (last_result.found && $urandom_range(0, 4) != 0)
                send_op(OP_EOI, last_result.selected_line, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 1) == 0)
                send_op(OP_LEVEL, line, 1'b0);
            if ($urandom_range(0, 3) == 0)
                send_op(OP_MASK, line, 1'($urandom_range(0, 1)));
        end
    endtask

    // weighted operation mix, lines often from a small hot set
    task automatic test_random_mix(input int n_ops);
        int               stop_at;
        int               pick;
        logic [LINE_W-1:0] hot_lines[8];
        logic [LINE_W-1:0] line;
        logic [OPCODE_W-1:0] op;
        stop_at = ops_sent + n_ops;
        foreach (hot_lines[i])
            hot_lines[i] = LINE_W'($urandom_range(0, 255));
        while (ops_sent < stop_at)
        begin
            // new phase every so often: idling mode and hot set
            if ($urandom_range(0, 63) == 0)
            begin
                no_idle = ($urandom_range(0, 2) == 0);
                foreach (hot_lines[i])
                    hot_lines[i] = LINE_W'($urandom_range(0, 255));
            end
            if ($urandom_range(0, 1) == 0)
                line = hot_lines[$urandom_range(0, 7)];
            else
                line = LINE_W'($urandom_range(0, 255));
            pick = $urandom_range(0, 99);
            if (pick < 30)
                op = OP_GET;
            else if (pick < 55)
                op = OP_LEVEL;
            else if (pick < 70)
                op = OP_UNMASK;
            else if (pick < 80)
                op = OP_MASK;
            else if (pick < 95)
                op = OP_EOI;
            else
                op = OPCODE_W'($urandom_range(5, 7));
            send_op(op, line, 1'($urandom_range(0, 1)));
        end
    endtask

    // stimulus sequence
    initial
    begin
        error_count = 0;
        ops_sent    = 0;
        no_idle     = 1'b0;
        req_if.valid         = 1'b0;
        req_if.opcode        = OP_MASK;
        req_if.line_number   = '0;
        req_if.pending_level = 1'b0;
        for (int i = 0; i < NUM_WORDS; i++)
        begin
            enable_shadow[i]  = '0;
            armed_shadow[i]   = '1;
            pending_shadow[i] = '0;
        end
        rst_n = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        test_first_grant();
        test_line_extremes();
        test_spare_opcodes();
        wait_drained();
        test_service_flows(650);
        wait_drained();
        test_random_mix(680);
        no_idle = 1'b0;
        wait_drained();
        repeat (DRAIN_TAIL) @(posedge clk);

        if (error_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/maskirq_pkg.sv
hw/rtl/maskirq_if.sv
hw/rtl/masked_interrupt_priority_select.sv
tb/tb.sv
